FILE: src/lrtm_pkg.sv
// Shared constants, types and codes for the linear recurrence term unit.
`default_nettype none

package lrtm_pkg;

   // Field and matrix geometry
   localparam int ORDER    = 4;
   localparam int ROW_W    = $clog2(ORDER);
   localparam int REG_W    = 12;
   localparam int N_W      = 62;
   localparam int EXP_BITS = 61;
   localparam int MODULUS  = 2553;

   // Register file
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TERM_1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TERM_2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TERM_3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TERM_4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAG_1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAG_2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAG_3  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAG_4  = 3'd7;

   // Multiply-reduce widths: four 12x12 products summed, then a
   // reciprocal multiply estimates the quotient to within one
   localparam int PROD_W    = 2 * REG_W;
   localparam int SUM_W     = PROD_W + ROW_W;
   localparam int MOD_W     = $clog2(MODULUS);
   localparam int T_W       = MOD_W + 1;
   localparam int RED_SHIFT = SUM_W + REG_W;
   localparam int RECIP_W   = RED_SHIFT - $clog2(MODULUS) + 2;
   localparam int QP_W      = SUM_W + RECIP_W;
   localparam int Q_W       = QP_W - RED_SHIFT;
   localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((64'd1 << RED_SHIFT) / MODULUS);
   localparam logic [SUM_W-1:0]   MOD_SUM   = SUM_W'(MODULUS);
   localparam logic [T_W-1:0]     MOD_T     = T_W'(MODULUS);
   localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ORDER - 1);

   // Operation codes for the multiply unit
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_ACC = 2'd0;  // acc row times base
   localparam logic [OP_W-1:0] OP_SQ  = 2'd1;  // one row of base squared
   localparam logic [OP_W-1:0] OP_DOT = 2'd2;  // acc row dotted with initial terms

   typedef logic [REG_W-1:0]          elem_type;
   typedef elem_type [ORDER-1:0]      row_type;
   typedef row_type  [ORDER-1:0]      mat_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ROW_W-1:0] row;
   } tag_type;

   // Controller to datapath
   typedef struct packed {
      logic    load;
      logic    issue;
      tag_type tag;
      logic    commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_short;
      logic exp_zero;
      logic exp_last;
      logic exp_bit0;
      logic pipe_busy;
   } status_type;

   // Configuration: index 0 is term 1 / lag 1
   typedef struct packed {
      row_type init;
      row_type coef;
   } cfg_type;

endpackage

`default_nettype wire

FILE: src/linear_recurrence_term_mod.sv
// Top level: register file, controller and datapath for the recurrence term unit.
//
//   Channel   Ports                              Handshake
//   --------  ---------------------------------  ---------------------------------
//   query     start, busy, req_term_index        beat taken when start & !busy
//   result    rsp_valid, rsp_term_value          one-cycle strobe, cannot be held
//   config    csr_we, csr_index, csr_wdata       write taken when csr_we is high
//
// Indexes 0 to 4 answer without the multiply unit.
// Otherwise each bit of n-1 up to its top set bit takes a pass on the
// shared 4-stage multiply unit (an accumulate where the bit is set, four
// row squarings below the top bit, then its drain), and the final dot product follows.
// Reset clears the register file to zero and returns the controller to idle.
// Results leave on a strobe; no stall is possible from the receiver side.
`default_nettype none

module linear_recurrence_term_mod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [61:0] req_term_index,
   output logic             rsp_valid,
   output logic [11:0]      rsp_term_value,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   import lrtm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   elem_type   result;

   // Register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INIT_TERM_1: cfg_in.init[0] = csr_wdata;
            CSR_INIT_TERM_2: cfg_in.init[1] = csr_wdata;
            CSR_INIT_TERM_3: cfg_in.init[2] = csr_wdata;
            CSR_INIT_TERM_4: cfg_in.init[3] = csr_wdata;
            CSR_COEF_LAG_1:  cfg_in.coef[0] = csr_wdata;
            CSR_COEF_LAG_2:  cfg_in.coef[1] = csr_wdata;
            CSR_COEF_LAG_3:  cfg_in.coef[2] = csr_wdata;
            CSR_COEF_LAG_4:  cfg_in.coef[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lrtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lrtm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .term_index (req_term_index),
      .status     (status),
      .result     (result)
   );

   assign rsp_term_value = result;

endmodule

`default_nettype wire

FILE: src/lrtm_mulmod.sv
// Pipelined row-times-matrix multiply unit with reduction modulo the modulus.
`default_nettype none

module lrtm_mulmod (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire lrtm_pkg::tag_type in_tag,
   input  wire lrtm_pkg::row_type in_a,
   input  wire lrtm_pkg::mat_type in_b,
   output logic                   out_valid,
   output lrtm_pkg::tag_type      out_tag,
   output lrtm_pkg::row_type      out_r,
   output logic                   busy
);
   import lrtm_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   logic [ORDER-1:0][ORDER-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [ORDER-1:0][SUM_W-1:0]             sum_ff, sum_in;
   logic [ORDER-1:0][QP_W-1:0]              qp_ff, qp_in;
   logic [ORDER-1:0][SUM_W-1:0]             sum3_ff;
   logic [ORDER-1:0][T_W-1:0]               t_ff, t_in;
   logic [ORDER-1:0][Q_W-1:0]               quot;
   logic [ORDER-1:0][SUM_W-1:0]             qm;
   logic [ORDER-1:0][SUM_W-1:0]             t_full;

   // Stage 1: sixteen products, lane j takes column j
   always_comb begin
      for (int j = 0; j < ORDER; j++) begin
         for (int k = 0; k < ORDER; k++) begin
            prod_in[j][k] = PROD_W'(in_a[k]) * PROD_W'(in_b[k][j]);
         end
      end
   end

   // Stage 2: sum of four products per lane
   always_comb begin
      for (int j = 0; j < ORDER; j++) begin
         sum_in[j] = '0;
         for (int k = 0; k < ORDER; k++) begin
            sum_in[j] = sum_in[j] + SUM_W'(prod_ff[j][k]);
         end
      end
   end

   // Stage 3: quotient estimate by reciprocal multiply
   always_comb begin
      for (int j = 0; j < ORDER; j++) begin
         qp_in[j] = QP_W'(sum_ff[j]) * QP_W'(MOD_RECIP);
      end
   end

   // Stage 4: remainder, known to sit below twice the modulus
   always_comb begin
      for (int j = 0; j < ORDER; j++) begin
         quot[j]   = qp_ff[j][QP_W-1:RED_SHIFT];
         qm[j]     = SUM_W'(quot[j]) * MOD_SUM;
         t_full[j] = sum3_ff[j] - qm[j];
         t_in[j]   = t_full[j][T_W-1:0];
      end
   end

   // Final correction on the way out
   always_comb begin
      for (int j = 0; j < ORDER; j++) begin
         if (t_ff[j] >= MOD_T) begin
            out_r[j] = REG_W'(t_ff[j] - MOD_T);
         end else begin
            out_r[j] = REG_W'(t_ff[j]);
         end
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      tag4_ff <= tag3_ff;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      qp_ff   <= qp_in;
      sum3_ff <= sum_ff;
      t_ff    <= t_in;
   end

   assign out_valid = v4_ff;
   assign out_tag   = tag4_ff;
   assign busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

`default_nettype wire

FILE: src/lrtm_datapath.sv
// Datapath: base matrix, its square, the accumulator row, exponent and result.
`default_nettype none

module lrtm_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrtm_pkg::cmd_type    cmd,
   input  wire lrtm_pkg::cfg_type    cfg,
   input  wire logic [61:0]          term_index,
   output lrtm_pkg::status_type      status,
   output lrtm_pkg::elem_type        result
);
   import lrtm_pkg::*;

   mat_type  base_ff, base_in;
   mat_type  sq_ff, sq_in;
   row_type  acc_ff, acc_in;
   logic [EXP_BITS-1:0] x_ff, x_in;
   logic     short_ff, short_in;
   elem_type res_ff, res_in;

   logic [N_W-1:0] n_minus_1;
   logic     n_small;
   elem_type direct_val;
   mat_type  companion;
   row_type  ident_row;
   mat_type  dot_mat;

   row_type  op_a;
   mat_type  op_b;
   logic     mm_valid;
   tag_type  mm_tag;
   row_type  mm_r;
   logic     mm_busy;

   // Query decode: small indexes answer straight from the registers
   always_comb begin
      n_minus_1  = term_index - N_W'(1);
      n_small    = (term_index <= N_W'(ORDER));
      direct_val = '0;
      for (int k = 0; k < ORDER; k++) begin
         if (term_index == N_W'(k + 1)) begin
            direct_val = cfg.init[k];
         end
      end
   end

   // Companion matrix, identity row and the dot-product operand
   always_comb begin
      companion = '0;
      ident_row = '0;
      dot_mat   = '0;
      ident_row[0] = REG_W'(1);
      for (int i = 0; i < ORDER - 1; i++) begin
         companion[i][i+1] = REG_W'(1);
      end
      for (int j = 0; j < ORDER; j++) begin
         companion[ORDER-1][j] = cfg.coef[ORDER-1-j];
         dot_mat[j][0]         = cfg.init[j];
      end
   end

   // Operand select for the multiply unit
   always_comb begin
      case (cmd.tag.op)
         OP_ACC: begin
            op_a = acc_ff;
            op_b = base_ff;
         end
         OP_SQ: begin
            op_a = base_ff[cmd.tag.row];
            op_b = base_ff;
         end
         OP_DOT: begin
            op_a = acc_ff;
            op_b = dot_mat;
         end
         default: begin
            op_a = acc_ff;
            op_b = base_ff;
         end
      endcase
   end

   lrtm_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .in_tag    (cmd.tag),
      .in_a      (op_a),
      .in_b      (op_b),
      .out_valid (mm_valid),
      .out_tag   (mm_tag),
      .out_r     (mm_r),
      .busy      (mm_busy)
   );

   // Next values: load, commit of a squaring, writeback from the unit
   always_comb begin
      base_in  = base_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      short_in = short_ff;
      res_in   = res_ff;
      if (cmd.load) begin
         base_in  = companion;
         acc_in   = ident_row;
         x_in     = n_minus_1[EXP_BITS-1:0];
         short_in = n_small;
         res_in   = direct_val;
      end else if (cmd.commit) begin
         base_in = sq_ff;
         x_in    = x_ff >> 1;
      end
      if (mm_valid) begin
         case (mm_tag.op)
            OP_ACC:  acc_in            = mm_r;
            OP_SQ:   sq_in[mm_tag.row] = mm_r;
            OP_DOT:  res_in            = mm_r[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      short_ff <= short_in;
      res_ff   <= res_in;
   end

   always_comb begin
      status.is_short  = short_ff;
      status.exp_zero  = (x_ff == '0);
      status.exp_last  = (x_ff[EXP_BITS-1:1] == '0);
      status.exp_bit0  = x_ff[0];
      status.pipe_busy = mm_busy;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

FILE: src/lrtm_ctrl.sv
// Controller: sequences square-and-multiply passes and the final dot product.
`default_nettype none

module lrtm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire lrtm_pkg::status_type status,
   output lrtm_pkg::cmd_type         cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import lrtm_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHECK     = 3'd1;
   localparam logic [2:0] ST_ISSUE     = 3'd2;
   localparam logic [2:0] ST_DRAIN     = 3'd3;
   localparam logic [2:0] ST_COMMIT    = 3'd4;
   localparam logic [2:0] ST_DOT       = 3'd5;
   localparam logic [2:0] ST_DOT_DRAIN = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             acc_pend_ff, acc_pend_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      acc_pend_in = acc_pend_ff;
      row_in      = row_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_short) begin
               state_in = ST_FINISH;
            end else if (status.exp_zero) begin
               state_in = ST_DOT;
            end else begin
               acc_pend_in = status.exp_bit0;
               row_in      = '0;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (acc_pend_ff) begin
               cmd.tag.op  = OP_ACC;
               acc_pend_in = 1'b0;
               // top exponent bit: no further squaring needed
               if (status.exp_last) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               cmd.tag.op  = OP_SQ;
               cmd.tag.row = row_ff;
               row_in      = ROW_W'(row_ff + 1'b1);
               if (row_ff == ROW_LAST) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DOT: begin
            cmd.issue  = 1'b1;
            cmd.tag.op = OP_DOT;
            state_in   = ST_DOT_DRAIN;
         end
         ST_DOT_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         acc_pend_ff <= 1'b0;
         row_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         acc_pend_ff <= acc_pend_in;
         row_ff      <= row_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_FINISH);

   // Result strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Squared matrix only taken once the unit has drained
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.pipe_busy)
      else $error("commit while multiply unit still busy");

   // A taken query keeps the block busy
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy)
      else $error("busy not raised after query accepted");

   // The dot issue shows up in the multiply pipeline
   a_dot_in_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOT) |=> status.pipe_busy)
      else $error("dot product issue lost");

endmodule

`default_nettype wire
